FILE: rtl/qnsm_pkg.sv
`timescale 1ns / 1ps

package qnsm_pkg;

  localparam int NODE_SLOTS = 16;
  localparam int NODE_ID_W  = 5;
  localparam int IDX_W      = $clog2(NODE_SLOTS);
  localparam int CNT_W      = $clog2(NODE_SLOTS + 1);
  localparam int TL_W       = 32;
  localparam int MASK_OUT_W = 16;
  localparam int REQ_W      = 2;
  localparam int EV_W       = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [NODE_SLOTS-1:0] mask_t;

  typedef enum logic [1:0] {
    ST_DISABLED  = 2'd0,
    ST_RECOVERY  = 2'd1,
    ST_RECOVERED = 2'd2,
    ST_ONLINE    = 2'd3
  } status_t;

  localparam logic [REQ_W-1:0] REQ_NEIGHBOR   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SELF       = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CONNECT    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DISCONNECT = 2'd3;

  localparam logic [EV_W-1:0] NEV_CLIQUE_DIS   = 4'd0;
  localparam logic [EV_W-1:0] NEV_RX_START     = 4'd1;
  localparam logic [EV_W-1:0] NEV_TX_RECOVERY  = 4'd2;
  localparam logic [EV_W-1:0] NEV_TX_RECOVERED = 4'd3;
  localparam logic [EV_W-1:0] NEV_CAUGHT_UP    = 4'd4;

  localparam logic [EV_W-1:0] SEV_CLIQUE_DIS   = 4'd1;
  localparam logic [EV_W-1:0] SEV_RECOV_FIN_A  = 4'd6;
  localparam logic [EV_W-1:0] SEV_RECOV_FIN_B  = 4'd7;

  localparam logic [CFG_IDX_W-1:0] REG_NODES_IN_USE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SELF_ID       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAJOR_NODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFEREE_GRANT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIQUE_MASK   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOPPED_MASK  = 3'd5;

endpackage

FILE: rtl/qnsm_if.sv
`timescale 1ns / 1ps

interface qnsm_in_if;
  logic                             valid;
  logic                             ready;
  logic [qnsm_pkg::REQ_W-1:0]       req_type;
  logic [qnsm_pkg::NODE_ID_W-1:0]   node_id;
  logic [qnsm_pkg::EV_W-1:0]        event_code;

  modport source (output valid, output req_type, output node_id, output event_code,
                  input ready);
  modport sink (input valid, input req_type, input node_id, input event_code,
                output ready);
endinterface

interface qnsm_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        node_status;
  logic                              status_changed;
  logic [qnsm_pkg::MASK_OUT_W-1:0]   disabled_nodes;
  logic [qnsm_pkg::MASK_OUT_W-1:0]   unreachable_nodes;
  logic [qnsm_pkg::MASK_OUT_W-1:0]   receiver_nodes;
  logic [qnsm_pkg::MASK_OUT_W-1:0]   sender_nodes;
  logic [qnsm_pkg::TL_W-1:0]         restart_count;
  logic [qnsm_pkg::TL_W-1:0]         node_timeline;

  modport source (output valid, output node_status, output status_changed,
                  output disabled_nodes, output unreachable_nodes, output receiver_nodes,
                  output sender_nodes, output restart_count, output node_timeline,
                  input ready);
  modport sink (input valid, input node_status, input status_changed,
                input disabled_nodes, input unreachable_nodes, input receiver_nodes,
                input sender_nodes, input restart_count, input node_timeline,
                output ready);
endinterface

FILE: rtl/qnsm_ram.sv
`timescale 1ns / 1ps

module qnsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/qnsm_count.sv
`timescale 1ns / 1ps

module qnsm_count (
  input  qnsm_pkg::mask_t                mask,
  input  qnsm_pkg::mask_t                span,
  output logic [qnsm_pkg::CNT_W-1:0]     ones
);

  qnsm_pkg::mask_t live;

  assign live = mask & span;

  always_comb begin
    ones = '0;
    for (int i = 0; i < qnsm_pkg::NODE_SLOTS; i++) begin
      ones = ones + qnsm_pkg::CNT_W'(live[i]);
    end
  end

endmodule

FILE: rtl/quorum_node_status_machine_top.sv
`timescale 1ns / 1ps

// Membership status of one cluster node. Each accepted word (neighbor event, self event,
// link up, link down) first updates the node masks, then the majority check runs up to
// four chained passes. In each pass the shared popcount unit counts one mask (lost links,
// disabled, receivers, senders) per cycle, then a decide step moves the status.
// Bumping a node timeline is a read-modify-write on the timeline RAM (one read port, one
// write port), done at most twice per word. A link-down of a node already unreachable
// skips the check and goes straight to the result load; otherwise the passes and
// any timeline bumps run first; the load waits while the previous result is unread.
// in_ready returns as the result is loaded, and the result register lets the next word in.
// The 16-entry timeline RAM carries a valid bit per entry, so no clearing pass is needed.
module quorum_node_status_machine_top (
  input  logic                              clk,
  input  logic                              rst_n,
  qnsm_in_if.sink                           in_ch,
  qnsm_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [qnsm_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [qnsm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_APPLY  = 8'b0000_0010,
    S_COUNT  = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_TL_RD  = 8'b0001_0000,
    S_TL_WR  = 8'b0010_0000,
    S_FIN_RD = 8'b0100_0000,
    S_FIN_LD = 8'b1000_0000
  } state_t;

  localparam int NW = qnsm_pkg::NODE_ID_W;
  localparam int CW = qnsm_pkg::CNT_W;

  function automatic qnsm_pkg::mask_t id_bit(input logic [NW-1:0] id);
    qnsm_pkg::mask_t m;
    m = '0;
    for (int i = 0; i < qnsm_pkg::NODE_SLOTS; i++) begin
      m[i] = (id == NW'(i + 1));
    end
    return m;
  endfunction

  function automatic logic id_ok(input logic [NW-1:0] id);
    return (id != '0) && ((NW + 1)'(id) <= (NW + 1)'(qnsm_pkg::NODE_SLOTS));
  endfunction

  function automatic logic [qnsm_pkg::IDX_W-1:0] id_idx(input logic [NW-1:0] id);
    logic [NW-1:0] d;
    d = id - NW'(1);
    return d[qnsm_pkg::IDX_W-1:0];
  endfunction

  function automatic qnsm_pkg::mask_t range_mask(input logic [NW-1:0] n);
    qnsm_pkg::mask_t m;
    for (int i = 0; i < qnsm_pkg::NODE_SLOTS; i++) begin
      m[i] = ((NW + 8)'(i) < (NW + 8)'(n));
    end
    return m;
  endfunction

  // configuration
  logic [NW-1:0]                       nodes_r;
  logic [NW-1:0]                       self_r;
  logic                                major_r;
  logic                                referee_r;
  logic [qnsm_pkg::CFG_DATA_W-1:0]     clique_r;
  logic [qnsm_pkg::CFG_DATA_W-1:0]     stopped_r;

  // sequencer and node state
  state_t                              state_r, state_nxt;
  logic [qnsm_pkg::REQ_W-1:0]          req_r, req_nxt;
  logic [NW-1:0]                       id_r, id_nxt;
  logic [qnsm_pkg::EV_W-1:0]           ev_r, ev_nxt;
  qnsm_pkg::status_t                   status_r, status_nxt;
  qnsm_pkg::status_t                   start_r, start_nxt;
  qnsm_pkg::mask_t                     dis_r, dis_nxt;
  qnsm_pkg::mask_t                     unr_r, unr_nxt;
  qnsm_pkg::mask_t                     rx_r, rx_nxt;
  qnsm_pkg::mask_t                     tx_r, tx_nxt;
  logic [qnsm_pkg::TL_W-1:0]           rcnt_r, rcnt_nxt;
  logic [1:0]                          cidx_r, cidx_nxt;
  logic [1:0]                          pass_r, pass_nxt;
  logic [CW-1:0]                       c_unr_r, c_unr_nxt;
  logic [CW-1:0]                       c_dis_r, c_dis_nxt;
  logic [CW-1:0]                       c_rx_r, c_rx_nxt;
  logic [CW-1:0]                       c_tx_r, c_tx_nxt;
  logic [qnsm_pkg::IDX_W-1:0]          tl_addr_r, tl_addr_nxt;
  logic                                tl_ret_r, tl_ret_nxt;
  qnsm_pkg::mask_t                     vld_r, vld_nxt;

  // result register
  logic                                out_valid_r, out_valid_nxt;
  logic [1:0]                          o_status_r, o_status_nxt;
  logic                                o_changed_r, o_changed_nxt;
  logic [qnsm_pkg::MASK_OUT_W-1:0]     o_dis_r, o_dis_nxt;
  logic [qnsm_pkg::MASK_OUT_W-1:0]     o_unr_r, o_unr_nxt;
  logic [qnsm_pkg::MASK_OUT_W-1:0]     o_rx_r, o_rx_nxt;
  logic [qnsm_pkg::MASK_OUT_W-1:0]     o_tx_r, o_tx_nxt;
  logic [qnsm_pkg::TL_W-1:0]           o_rcnt_r, o_rcnt_nxt;
  logic [qnsm_pkg::TL_W-1:0]           o_tl_r, o_tl_nxt;

  // datapath
  qnsm_pkg::mask_t                     b, sb, span, cnt_mask;
  logic [CW-1:0]                       cnt_ones;
  logic [CW-1:0]                       n_cnt, half, n_conn, n_en;
  logic                                ok, en_ok, rcvd_ok;
  logic                                ram_we;
  logic [qnsm_pkg::IDX_W-1:0]          ram_raddr;
  logic [qnsm_pkg::TL_W-1:0]           ram_rdata, tl_inc;
  logic                                do_dis, run;

  assign b    = id_bit(id_r);
  assign sb   = id_bit(self_r);
  assign span = range_mask(nodes_r);

  always_comb begin
    unique case (cidx_r)
      2'd0:    cnt_mask = unr_r;
      2'd1:    cnt_mask = dis_r;
      2'd2:    cnt_mask = rx_r;
      default: cnt_mask = tx_r;
    endcase
  end

  qnsm_count u_count (
    .mask (cnt_mask),
    .span (span),
    .ones (cnt_ones)
  );

  assign n_cnt  = ((NW + 1)'(nodes_r) > (NW + 1)'(qnsm_pkg::NODE_SLOTS)) ?
                  CW'(qnsm_pkg::NODE_SLOTS) : CW'(nodes_r);
  assign half   = n_cnt >> 1;
  assign n_conn = n_cnt - c_unr_r;
  assign n_en   = n_cnt - c_dis_r;

  always_comb begin
    logic base;
    base  = (n_conn > half) || ((n_conn == half) && (major_r || referee_r));
    ok    = base && ((|(qnsm_pkg::mask_t'(clique_r) & sb)) || referee_r)
                 && !(|(qnsm_pkg::mask_t'(stopped_r) & sb));
    en_ok = (n_en > half) || ((n_en == half) && referee_r);
    rcvd_ok = (({1'b0, c_rx_r} + (CW + 1)'(1)) == {1'b0, n_en})
           && (({1'b0, c_tx_r} + (CW + 1)'(1)) == {1'b0, n_en})
           && (n_en == n_conn);
  end

  assign ram_raddr = (state_r == S_TL_RD || state_r == S_TL_WR) ? tl_addr_r : id_idx(id_r);
  assign tl_inc    = (vld_r[tl_addr_r] ? ram_rdata : '0) + qnsm_pkg::TL_W'(1);

  qnsm_ram #(
    .WIDTH (qnsm_pkg::TL_W),
    .DEPTH (qnsm_pkg::NODE_SLOTS)
  ) u_tl_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tl_addr_r),
    .wdata (tl_inc),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    id_nxt        = id_r;
    ev_nxt        = ev_r;
    status_nxt    = status_r;
    start_nxt     = start_r;
    dis_nxt       = dis_r;
    unr_nxt       = unr_r;
    rx_nxt        = rx_r;
    tx_nxt        = tx_r;
    rcnt_nxt      = rcnt_r;
    cidx_nxt      = cidx_r;
    pass_nxt      = pass_r;
    c_unr_nxt     = c_unr_r;
    c_dis_nxt     = c_dis_r;
    c_rx_nxt      = c_rx_r;
    c_tx_nxt      = c_tx_r;
    tl_addr_nxt   = tl_addr_r;
    tl_ret_nxt    = tl_ret_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    o_status_nxt  = o_status_r;
    o_changed_nxt = o_changed_r;
    o_dis_nxt     = o_dis_r;
    o_unr_nxt     = o_unr_r;
    o_rx_nxt      = o_rx_r;
    o_tx_nxt      = o_tx_r;
    o_rcnt_nxt    = o_rcnt_r;
    o_tl_nxt      = o_tl_r;
    ram_we        = 1'b0;
    do_dis        = 1'b0;
    run           = 1'b1;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          req_nxt   = in_ch.req_type;
          id_nxt    = in_ch.node_id;
          ev_nxt    = in_ch.event_code;
          start_nxt = status_r;
          state_nxt = S_APPLY;
        end
      end

      S_APPLY: begin
        unique case (req_r)
          qnsm_pkg::REQ_NEIGHBOR: begin
            unique case (ev_r)
              qnsm_pkg::NEV_CLIQUE_DIS,
              qnsm_pkg::NEV_TX_RECOVERY:  do_dis = 1'b1;
              qnsm_pkg::NEV_RX_START:     rx_nxt = rx_r | b;
              qnsm_pkg::NEV_TX_RECOVERED: begin
                tx_nxt  = tx_r | b;
                dis_nxt = dis_r & ~b;
              end
              qnsm_pkg::NEV_CAUGHT_UP:    dis_nxt = dis_r & ~b;
              default: ;
            endcase
          end
          qnsm_pkg::REQ_SELF: begin
            if (ev_r == qnsm_pkg::SEV_CLIQUE_DIS) begin
              dis_nxt  = dis_r | sb;
              rcnt_nxt = rcnt_r + qnsm_pkg::TL_W'(1);
            end else if (ev_r == qnsm_pkg::SEV_RECOV_FIN_A ||
                         ev_r == qnsm_pkg::SEV_RECOV_FIN_B) begin
              dis_nxt  = dis_r & ~sb;
              rcnt_nxt = rcnt_r + qnsm_pkg::TL_W'(1);
            end
          end
          qnsm_pkg::REQ_CONNECT: unr_nxt = unr_r & ~b;
          default: begin
            // link already down: nothing to do, skip the check
            if (|(unr_r & b)) begin
              run = 1'b0;
            end else begin
              unr_nxt = unr_r | b;
              do_dis  = 1'b1;
            end
          end
        endcase

        if (do_dis && (|b) && !(|(dis_r & b))) begin
          dis_nxt     = dis_r | b;
          tl_addr_nxt = id_idx(id_r);
          tl_ret_nxt  = 1'b1;
          state_nxt   = S_TL_RD;
        end else if (run) begin
          cidx_nxt  = 2'd0;
          pass_nxt  = 2'd0;
          state_nxt = S_COUNT;
        end else begin
          state_nxt = S_FIN_RD;
        end
      end

      S_COUNT: begin
        unique case (cidx_r)
          2'd0:    c_unr_nxt = cnt_ones;
          2'd1:    c_dis_nxt = cnt_ones;
          2'd2:    c_rx_nxt  = cnt_ones;
          default: c_tx_nxt  = cnt_ones;
        endcase
        cidx_nxt = cidx_r + 2'd1;
        if (cidx_r == 2'd3) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (!ok || (status_r == qnsm_pkg::ST_ONLINE && !en_ok)) begin
          // drop to disabled and disable self
          if (status_r != qnsm_pkg::ST_DISABLED) begin
            rx_nxt     = '0;
            tx_nxt     = '0;
            rcnt_nxt   = rcnt_r + qnsm_pkg::TL_W'(1);
            status_nxt = qnsm_pkg::ST_DISABLED;
          end
          if ((|sb) && !(|(dis_r & sb))) begin
            dis_nxt     = dis_r | sb;
            tl_addr_nxt = id_idx(self_r);
            tl_ret_nxt  = 1'b0;
            state_nxt   = S_TL_RD;
          end else begin
            state_nxt = S_FIN_RD;
          end
        end else begin
          logic adv;
          adv = 1'b0;
          unique case (status_r)
            qnsm_pkg::ST_DISABLED: begin
              status_nxt = qnsm_pkg::ST_RECOVERY;
              adv        = 1'b1;
            end
            qnsm_pkg::ST_RECOVERY: begin
              if (!(|(dis_r & sb))) begin
                status_nxt = qnsm_pkg::ST_RECOVERED;
                adv        = 1'b1;
              end
            end
            qnsm_pkg::ST_RECOVERED: begin
              if (rcvd_ok) begin
                status_nxt = qnsm_pkg::ST_ONLINE;
                adv        = 1'b1;
              end
            end
            default: ;
          endcase
          if (adv && pass_r != 2'd3) begin
            pass_nxt  = pass_r + 2'd1;
            cidx_nxt  = 2'd0;
            state_nxt = S_COUNT;
          end else begin
            state_nxt = S_FIN_RD;
          end
        end
      end

      S_TL_RD: state_nxt = S_TL_WR;

      S_TL_WR: begin
        ram_we              = 1'b1;
        vld_nxt[tl_addr_r]  = 1'b1;
        if (tl_ret_r) begin
          cidx_nxt  = 2'd0;
          pass_nxt  = 2'd0;
          state_nxt = S_COUNT;
        end else begin
          state_nxt = S_FIN_RD;
        end
      end

      S_FIN_RD: state_nxt = S_FIN_LD;

      S_FIN_LD: begin
        // hold until the result register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = status_r;
          o_changed_nxt = (status_r != start_r);
          o_dis_nxt     = qnsm_pkg::MASK_OUT_W'(dis_r);
          o_unr_nxt     = qnsm_pkg::MASK_OUT_W'(unr_r);
          o_rx_nxt      = qnsm_pkg::MASK_OUT_W'(rx_r);
          o_tx_nxt      = qnsm_pkg::MASK_OUT_W'(tx_r);
          o_rcnt_nxt    = rcnt_r;
          o_tl_nxt      = (id_ok(id_r) && vld_r[id_idx(id_r)]) ? ram_rdata : '0;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r   <= NW'(3);
      self_r    <= NW'(1);
      major_r   <= 1'b0;
      referee_r <= 1'b0;
      clique_r  <= '1;
      stopped_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        qnsm_pkg::REG_NODES_IN_USE:  nodes_r   <= cfg_wdata[NW-1:0];
        qnsm_pkg::REG_SELF_ID:       self_r    <= cfg_wdata[NW-1:0];
        qnsm_pkg::REG_MAJOR_NODE:    major_r   <= cfg_wdata[0];
        qnsm_pkg::REG_REFEREE_GRANT: referee_r <= cfg_wdata[0];
        qnsm_pkg::REG_CLIQUE_MASK:   clique_r  <= cfg_wdata;
        qnsm_pkg::REG_STOPPED_MASK:  stopped_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= qnsm_pkg::ST_DISABLED;
      dis_r       <= '0;
      unr_r       <= '0;
      rx_r        <= '0;
      tx_r        <= '0;
      rcnt_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      dis_r       <= dis_nxt;
      unr_r       <= unr_nxt;
      rx_r        <= rx_nxt;
      tx_r        <= tx_nxt;
      rcnt_r      <= rcnt_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    id_r        <= id_nxt;
    ev_r        <= ev_nxt;
    start_r     <= start_nxt;
    cidx_r      <= cidx_nxt;
    pass_r      <= pass_nxt;
    c_unr_r     <= c_unr_nxt;
    c_dis_r     <= c_dis_nxt;
    c_rx_r      <= c_rx_nxt;
    c_tx_r      <= c_tx_nxt;
    tl_addr_r   <= tl_addr_nxt;
    tl_ret_r    <= tl_ret_nxt;
    o_status_r  <= o_status_nxt;
    o_changed_r <= o_changed_nxt;
    o_dis_r     <= o_dis_nxt;
    o_unr_r     <= o_unr_nxt;
    o_rx_r      <= o_rx_nxt;
    o_tx_r      <= o_tx_nxt;
    o_rcnt_r    <= o_rcnt_nxt;
    o_tl_r      <= o_tl_nxt;
  end

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.node_status       = o_status_r;
  assign out_ch.status_changed    = o_changed_r;
  assign out_ch.disabled_nodes    = o_dis_r;
  assign out_ch.unreachable_nodes = o_unr_r;
  assign out_ch.receiver_nodes    = o_rx_r;
  assign out_ch.sender_nodes      = o_tx_r;
  assign out_ch.restart_count     = o_rcnt_r;
  assign out_ch.node_timeline     = o_tl_r;

endmodule

FILE: rtl/qnsm_checker.sv
`timescale 1ns / 1ps

module qnsm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_node_status
);

  // one word in flight: ready drops right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after a word was accepted");

  // a new result appears only as the sequencer returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result issued while the block is still busy");

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result valid or block busy after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_node_status))
    else $error("stalled result word changed");

endmodule

bind quorum_node_status_machine_top qnsm_checker u_qnsm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_node_status (out_ch.node_status)
);

FILE: tb/tb_quorum_node_status_machine_top.sv
`timescale 1ns / 1ps

module tb_quorum_node_status_machine_top;

  localparam logic [qnsm_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [qnsm_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int PHASES       = 10;
  localparam int PHASE_WORDS  = 150;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    qnsm_pkg::status_t st;
    logic              changed;
    qnsm_pkg::mask_t   dis;
    qnsm_pkg::mask_t   unr;
    qnsm_pkg::mask_t   rx;
    qnsm_pkg::mask_t   tx;
    logic [31:0]       restarts;
    logic [31:0]       tl;
  } status_word_t;

  class node_status_tracker;
    qnsm_pkg::status_t status;
    qnsm_pkg::mask_t   dis_m, unr_m, rx_m, tx_m;
    logic [31:0]       restarts;
    logic [31:0]       timeline [qnsm_pkg::NODE_SLOTS];
    logic [4:0]        cfg_nodes, cfg_self;
    logic              cfg_major, cfg_referee;
    qnsm_pkg::mask_t   cfg_clique, cfg_stopped;
    status_word_t      pending [$];
    int                errors;

    function new();
      status      = qnsm_pkg::ST_DISABLED;
      dis_m       = '0;
      unr_m       = '0;
      rx_m        = '0;
      tx_m        = '0;
      restarts    = '0;
      foreach (timeline[i]) timeline[i] = '0;
      cfg_nodes   = 5'd3;
      cfg_self    = 5'd1;
      cfg_major   = 1'b0;
      cfg_referee = 1'b0;
      cfg_clique  = '1;
      cfg_stopped = '0;
      errors      = 0;
    endfunction

    function void apply_config(logic [qnsm_pkg::CFG_IDX_W-1:0] idx,
                               logic [qnsm_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        qnsm_pkg::REG_NODES_IN_USE:  cfg_nodes   = data[4:0];
        qnsm_pkg::REG_SELF_ID:       cfg_self    = data[4:0];
        qnsm_pkg::REG_MAJOR_NODE:    cfg_major   = data[0];
        qnsm_pkg::REG_REFEREE_GRANT: cfg_referee = data[0];
        qnsm_pkg::REG_CLIQUE_MASK:   cfg_clique  = data[qnsm_pkg::NODE_SLOTS-1:0];
        qnsm_pkg::REG_STOPPED_MASK:  cfg_stopped = data[qnsm_pkg::NODE_SLOTS-1:0];
        default: ;
      endcase
    endfunction

    function qnsm_pkg::mask_t node_bit(logic [qnsm_pkg::NODE_ID_W-1:0] id);
      if (id >= 1 && id <= qnsm_pkg::NODE_SLOTS) return qnsm_pkg::mask_t'(1) << (id - 1);
      return '0;
    endfunction

    function int ones_below(qnsm_pkg::mask_t m, int n);
      int c;
      c = 0;
      for (int i = 0; i < n; i++) c += m[i];
      return c;
    endfunction

    function void disable_node(logic [qnsm_pkg::NODE_ID_W-1:0] id);
      qnsm_pkg::mask_t b;
      b = node_bit(id);
      if (b == '0 || (dis_m & b) != '0) return;
      dis_m |= b;
      timeline[id - 1] += 1;
    endfunction

    function void move_to(qnsm_pkg::status_t s);
      if (status == s) return;
      // dropping out tears down replication
      if (s == qnsm_pkg::ST_DISABLED) begin
        rx_m = '0;
        tx_m = '0;
        restarts += 1;
      end
      status = s;
    endfunction

    // one majority pass; returns 1 when the status advanced
    function bit run_pass();
      int              n, half, n_en, n_conn, n_rx, n_tx;
      qnsm_pkg::mask_t selfb;
      bit              ok;
      n      = (cfg_nodes > qnsm_pkg::NODE_SLOTS) ? qnsm_pkg::NODE_SLOTS : int'(cfg_nodes);
      half   = n / 2;
      n_en   = n - ones_below(dis_m, n);
      n_conn = n - ones_below(unr_m, n);
      n_rx   = ones_below(rx_m, n);
      n_tx   = ones_below(tx_m, n);
      selfb  = node_bit(cfg_self);
      ok = (n_conn >= half + 1) || (n_conn == half && (cfg_major || cfg_referee));
      if (ok && (cfg_clique & selfb) == '0 && !cfg_referee) ok = 1'b0;
      if (ok && (cfg_stopped & selfb) != '0) ok = 1'b0;
      if (!ok) begin
        move_to(qnsm_pkg::ST_DISABLED);
        disable_node(cfg_self);
        return 1'b0;
      end
      case (status)
        qnsm_pkg::ST_DISABLED: begin
          move_to(qnsm_pkg::ST_RECOVERY);
          return 1'b1;
        end
        qnsm_pkg::ST_RECOVERY: if ((dis_m & selfb) == '0) begin
          move_to(qnsm_pkg::ST_RECOVERED);
          return 1'b1;
        end
        qnsm_pkg::ST_RECOVERED: if (n_rx + 1 == n_en && n_tx + 1 == n_en && n_en == n_conn) begin
          move_to(qnsm_pkg::ST_ONLINE);
          return 1'b1;
        end
        default: if (!((n_en >= half + 1) || (n_en == half && cfg_referee))) begin
          move_to(qnsm_pkg::ST_DISABLED);
          disable_node(cfg_self);
        end
      endcase
      return 1'b0;
    endfunction

    function void accept_event(logic [qnsm_pkg::REQ_W-1:0] req,
                               logic [qnsm_pkg::NODE_ID_W-1:0] id,
                               logic [qnsm_pkg::EV_W-1:0] ev);
      qnsm_pkg::mask_t   b;
      qnsm_pkg::status_t start;
      bit                run;
      status_word_t      w;
      b     = node_bit(id);
      start = status;
      run   = 1'b1;
      case (req)
        qnsm_pkg::REQ_NEIGHBOR: begin
          case (ev)
            qnsm_pkg::NEV_CLIQUE_DIS, qnsm_pkg::NEV_TX_RECOVERY: disable_node(id);
            qnsm_pkg::NEV_RX_START:     rx_m |= b;
            qnsm_pkg::NEV_TX_RECOVERED: begin
              tx_m  |= b;
              dis_m &= ~b;
            end
            qnsm_pkg::NEV_CAUGHT_UP:    dis_m &= ~b;
            default: ;
          endcase
        end
        qnsm_pkg::REQ_SELF: begin
          if (ev == qnsm_pkg::SEV_CLIQUE_DIS) begin
            dis_m |= node_bit(cfg_self);
            restarts += 1;
          end else if (ev == qnsm_pkg::SEV_RECOV_FIN_A || ev == qnsm_pkg::SEV_RECOV_FIN_B) begin
            dis_m &= ~node_bit(cfg_self);
            restarts += 1;
          end
        end
        qnsm_pkg::REQ_CONNECT: unr_m &= ~b;
        default: begin
          // link already down: nothing to do, no check
          if ((unr_m & b) != '0) begin
            run = 1'b0;
          end else begin
            unr_m |= b;
            disable_node(id);
          end
        end
      endcase
      if (run) begin
        for (int p = 0; p < 4; p++) if (!run_pass()) break;
      end
      w.st       = status;
      w.changed  = (status != start);
      w.dis      = dis_m;
      w.unr      = unr_m;
      w.rx       = rx_m;
      w.tx       = tx_m;
      w.restarts = restarts;
      w.tl       = (b != '0) ? timeline[id - 1] : '0;
      pending.push_back(w);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want === got) return;
      errors++;
      $error("%s: expected %0h, got %0h", name, want, got);
    endfunction

    function void compare_result(status_word_t got);
      status_word_t want;
      if (pending.size() == 0) begin
        errors++;
        $error("result word with no event outstanding");
        return;
      end
      want = pending.pop_front();
      check_field("node_status",       32'(want.st),      32'(got.st));
      check_field("status_changed",    32'(want.changed), 32'(got.changed));
      check_field("disabled_nodes",    32'(want.dis),     32'(got.dis));
      check_field("unreachable_nodes", 32'(want.unr),     32'(got.unr));
      check_field("receiver_nodes",    32'(want.rx),      32'(got.rx));
      check_field("sender_nodes",      32'(want.tx),      32'(got.tx));
      check_field("restart_count",     want.restarts,     got.restarts);
      check_field("node_timeline",     want.tl,           got.tl);
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [qnsm_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [qnsm_pkg::CFG_DATA_W-1:0] cfg_wdata;
  bit                              idle_on;
  node_status_tracker              tracker;

  qnsm_in_if  in_if ();
  qnsm_out_if out_if ();

  quorum_node_status_machine_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // worst case per word: busy time plus the longest input gap and the longest result stall
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stall bursts while idling is on
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    status_word_t got;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.st       = qnsm_pkg::status_t'(out_if.node_status);
      got.changed  = out_if.status_changed;
      got.dis      = out_if.disabled_nodes;
      got.unr      = out_if.unreachable_nodes;
      got.rx       = out_if.receiver_nodes;
      got.tx       = out_if.sender_nodes;
      got.restarts = out_if.restart_count;
      got.tl       = out_if.node_timeline;
      tracker.compare_result(got);
    end
  end

  task automatic send_word(input logic [qnsm_pkg::REQ_W-1:0] req,
                           input logic [qnsm_pkg::NODE_ID_W-1:0] id,
                           input logic [qnsm_pkg::EV_W-1:0] ev);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.req_type   <= req;
    in_if.node_id    <= id;
    in_if.event_code <= ev;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    tracker.accept_event(req, id, ev);
  endtask

  // mostly well-formed membership traffic within the configured cluster, some noise
  task automatic send_random_word();
    int                             n, pick;
    logic [qnsm_pkg::REQ_W-1:0]     req;
    logic [qnsm_pkg::NODE_ID_W-1:0] id;
    logic [qnsm_pkg::EV_W-1:0]      ev;
    n = (tracker.cfg_nodes > qnsm_pkg::NODE_SLOTS) ? qnsm_pkg::NODE_SLOTS
                                                   : int'(tracker.cfg_nodes);
    if (n < 1) n = 1;
    id   = qnsm_pkg::NODE_ID_W'($urandom_range(1, n));
    ev   = '0;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      req = qnsm_pkg::REQ_NEIGHBOR;
      ev  = $urandom_range(0, 1) ? qnsm_pkg::NEV_RX_START : qnsm_pkg::NEV_TX_RECOVERED;
    end else if (pick < 52) begin
      req = qnsm_pkg::REQ_NEIGHBOR;
      case ($urandom_range(0, 2))
        0:       ev = qnsm_pkg::NEV_CLIQUE_DIS;
        1:       ev = qnsm_pkg::NEV_TX_RECOVERY;
        default: ev = qnsm_pkg::NEV_CAUGHT_UP;
      endcase
    end else if (pick < 62) begin
      req = qnsm_pkg::REQ_CONNECT;
    end else if (pick < 69) begin
      req = qnsm_pkg::REQ_DISCONNECT;
    end else if (pick < 80) begin
      req = qnsm_pkg::REQ_SELF;
      if ($urandom_range(0, 1)) begin
        ev = $urandom_range(0, 1) ? qnsm_pkg::SEV_RECOV_FIN_A : qnsm_pkg::SEV_RECOV_FIN_B;
      end else begin
        ev = qnsm_pkg::EV_W'($urandom_range(0, 8));
      end
    end else begin
      req = qnsm_pkg::REQ_W'($urandom_range(0, 3));
      id  = qnsm_pkg::NODE_ID_W'($urandom_range(0, 31));
      ev  = qnsm_pkg::EV_W'($urandom_range(0, 15));
    end
    send_word(req, id, ev);
  endtask

  task automatic write_reg(input logic [qnsm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [qnsm_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.apply_config(idx, data);
  endtask

  task automatic set_cluster(input logic [qnsm_pkg::CFG_DATA_W-1:0] nodes,
                             input logic [qnsm_pkg::CFG_DATA_W-1:0] self_w,
                             input logic major, input logic referee,
                             input qnsm_pkg::mask_t clique, input qnsm_pkg::mask_t stopped);
    write_reg(qnsm_pkg::REG_NODES_IN_USE,  nodes);
    write_reg(qnsm_pkg::REG_SELF_ID,       self_w);
    write_reg(qnsm_pkg::REG_MAJOR_NODE,    {15'($urandom), major});
    write_reg(qnsm_pkg::REG_REFEREE_GRANT, {15'($urandom), referee});
    write_reg(qnsm_pkg::REG_CLIQUE_MASK,   clique);
    write_reg(qnsm_pkg::REG_STOPPED_MASK,  stopped);
    // spare indexes must not disturb anything
    write_reg(REG_SPARE_LO, qnsm_pkg::CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_HI, qnsm_pkg::CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int              n, self_n;
    qnsm_pkg::mask_t selfb;
    tracker = new();
    idle_on = 1'b1;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= '0;
    cfg_wdata        <= '0;
    in_if.valid      <= 1'b0;
    in_if.req_type   <= '0;
    in_if.node_id    <= '0;
    in_if.event_code <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // three-node cluster at reset settings: bring up, lose quorum, recover
    send_word(qnsm_pkg::REQ_NEIGHBOR,   5'd2,  qnsm_pkg::NEV_RX_START);
    send_word(qnsm_pkg::REQ_NEIGHBOR,   5'd3,  qnsm_pkg::NEV_RX_START);
    send_word(qnsm_pkg::REQ_NEIGHBOR,   5'd2,  qnsm_pkg::NEV_TX_RECOVERED);
    send_word(qnsm_pkg::REQ_NEIGHBOR,   5'd3,  qnsm_pkg::NEV_TX_RECOVERED);
    send_word(qnsm_pkg::REQ_NEIGHBOR,   5'd1,  qnsm_pkg::NEV_CLIQUE_DIS);
    send_word(qnsm_pkg::REQ_SELF,       5'd0,  qnsm_pkg::SEV_CLIQUE_DIS);
    send_word(qnsm_pkg::REQ_SELF,       5'd0,  qnsm_pkg::SEV_RECOV_FIN_A);
    send_word(qnsm_pkg::REQ_DISCONNECT, 5'd2,  qnsm_pkg::NEV_CLIQUE_DIS);
    send_word(qnsm_pkg::REQ_DISCONNECT, 5'd2,  qnsm_pkg::NEV_CLIQUE_DIS);
    send_word(qnsm_pkg::REQ_DISCONNECT, 5'd3,  qnsm_pkg::NEV_CLIQUE_DIS);
    send_word(qnsm_pkg::REQ_CONNECT,    5'd3,  qnsm_pkg::NEV_CLIQUE_DIS);
    send_word(qnsm_pkg::REQ_SELF,       5'd31, qnsm_pkg::SEV_RECOV_FIN_B);
    send_word(qnsm_pkg::REQ_CONNECT,    5'd2,  4'd15);
    send_word(qnsm_pkg::REQ_NEIGHBOR,   5'd0,  qnsm_pkg::NEV_RX_START);
    send_word(qnsm_pkg::REQ_NEIGHBOR,   5'd31, qnsm_pkg::NEV_TX_RECOVERED);
    send_word(qnsm_pkg::REQ_NEIGHBOR,   5'd17, qnsm_pkg::NEV_CLIQUE_DIS);
    send_word(qnsm_pkg::REQ_NEIGHBOR,   5'd2,  4'd15);
    send_word(qnsm_pkg::REQ_SELF,       5'd1,  4'd15);
    send_word(qnsm_pkg::REQ_SELF,       5'd1,  4'd8);
    send_word(qnsm_pkg::REQ_SELF,       5'd1,  4'd5);
    send_word(qnsm_pkg::REQ_NEIGHBOR,   5'd3,  qnsm_pkg::NEV_TX_RECOVERY);
    send_word(qnsm_pkg::REQ_NEIGHBOR,   5'd3,  qnsm_pkg::NEV_CAUGHT_UP);
    send_word(qnsm_pkg::REQ_CONNECT,    5'd17, qnsm_pkg::NEV_CLIQUE_DIS);
    send_word(qnsm_pkg::REQ_DISCONNECT, 5'd0,  qnsm_pkg::NEV_CLIQUE_DIS);
    in_if.valid <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: set_cluster(16'd16, 16'd16, 1'b1, 1'b0, '1, '0);
        1: set_cluster(16'd1, 16'd1, 1'b0, 1'b0, 16'h0001, '0);
        2: set_cluster(16'd0, 16'd0, 1'b1, 1'b1, '0, '1);
        3: set_cluster(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, qnsm_pkg::mask_t'($urandom), '0);
        4: set_cluster(16'd4, 16'd2, 1'b1, 1'b0, '1, 16'h0008);
        default: begin
          n      = $urandom_range(2, 16);
          self_n = $urandom_range(1, n);
          selfb  = qnsm_pkg::mask_t'(1) << (self_n - 1);
          set_cluster({11'($urandom), 5'(n)}, {11'($urandom), 5'(self_n)},
                      1'($urandom), $urandom_range(0, 3) == 0,
                      ($urandom_range(0, 9) != 0) ? (qnsm_pkg::mask_t'($urandom) | selfb)
                                                  : qnsm_pkg::mask_t'($urandom),
                      ($urandom_range(0, 9) != 0) ? (qnsm_pkg::mask_t'($urandom) & ~selfb)
                                                  : qnsm_pkg::mask_t'($urandom));
        end
      endcase
      // hold both sides busy for the closing stretch
      if (ph == PHASES - 1) idle_on = 1'b0;
      repeat (PHASE_WORDS) send_random_word();
      in_if.valid <= 1'b0;
    end

    drain();
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
